[design/sem_pkg.sv]
// Shared types and constants for the Sobel edge magnitude block.
`timescale 1ns / 1ps
package sem_pkg;
	localparam int LINE_MAX_DEF = 1024;
	localparam int PIX_W = 8;
	localparam int MAG_W = 8;
	localparam int WIDTH_REG_W = 11;
	localparam int HEIGHT_REG_W = 16;
	localparam int CFG_DATA_W = 16;
	localparam int QDEPTH = 4;
	localparam int QCNT_W = $clog2(QDEPTH + 1);
	localparam int GRAD_W = PIX_W + 2;
	localparam int SUM_W = 2 * GRAD_W + 1;

	typedef enum logic [0:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		KIND_PIXEL = 1'b0,
		KIND_DRAIN = 1'b1
	} kind_t;

	typedef logic [PIX_W-1:0] pix_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] pixel_value;
	} in_item_t;

	typedef struct packed {
		logic [7:0] edge_value;
		logic       end_of_row;
		logic       end_of_image;
	} out_item_t;

	typedef struct packed {
		pix_t [8:0] px;
		logic       eor;
		logic       eoi;
	} job_t;
endpackage

[design/sem_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[design/sem_queue.sv]
// Job queue between the front and back parts.
`timescale 1ns / 1ps
module sem_queue import sem_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  job_t              push_data,
	input  logic              pop,
	output job_t              pop_data,
	output logic              nonempty,
	output logic              room2,
	output logic [QCNT_W-1:0] count
);
	localparam int PW = $clog2(QDEPTH);

	job_t              slot_q [QDEPTH];
	logic [PW-1:0]     wptr_q;
	logic [PW-1:0]     rptr_q;
	logic [QCNT_W-1:0] count_q;

	assign pop_data = slot_q[rptr_q];
	assign nonempty = (count_q != '0);
	assign room2 = (count_q <= QCNT_W'(QDEPTH - 2));
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + PW'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end
endmodule

[design/sem_front.sv]
// Front part: accepts items, keeps line stores and window, queues gradient jobs.
`timescale 1ns / 1ps
module sem_front import sem_pkg::*; #(
	parameter int LINE_MAX = LINE_MAX_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  in_item_t                in_data,
	input  logic [WIDTH_REG_W-1:0]  image_width,
	input  logic [HEIGHT_REG_W-1:0] image_height,
	input  logic                    q_room,
	output logic                    q_push,
	output job_t                    q_data
);
	localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
	localparam int WW = $clog2(LINE_MAX + 1);
	localparam int CMPW = ((WW > WIDTH_REG_W) ? WW : WIDTH_REG_W) + 1;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_PIX  = 6'b000010,
		ST_PIX2 = 6'b000100,
		ST_DR1  = 6'b001000,
		ST_DR2  = 6'b010000,
		ST_DR3  = 6'b100000
	} fstate_t;

	function automatic job_t build_job(input pix_t [8:0] w, input logic [1:0] li,
		input logic [1:0] ci, input logic [1:0] ri, input logic eor);
		job_t j;
		for (int r = 0; r < 3; r++) begin
			j.px[r*3]     = w[r*3 + int'(li)];
			j.px[r*3 + 1] = w[r*3 + int'(ci)];
			j.px[r*3 + 2] = w[r*3 + int'(ri)];
		end
		j.eor = eor;
		j.eoi = 1'b0;
		return j;
	endfunction

	fstate_t           state_q;
	logic [AW-1:0]     col_q;
	logic [AW-1:0]     drn_q;
	logic [15:0]       row_q;
	pix_t [8:0]        win_q;
	pix_t              pix_q;
	pix_t              tk_q, mk_q, tl_q, ml_q;
	job_t              jobb_q;

	logic [CMPW-1:0]   wlim;
	logic [15:0]       hlim;
	logic              c_last, k_last, rows_done, accept;
	logic [AW-1:0]     li, ri, raddr;
	pix_t              old_rd, prev_rd, old_wd;
	pix_t [8:0]        nwin;
	job_t              job_a, job_b, job_d;
	logic              has_a, has_b;

	always_comb begin
		wlim = CMPW'(image_width);
		if (image_width == '0) begin
			wlim = CMPW'(1);
		end else if (CMPW'(image_width) > CMPW'(LINE_MAX)) begin
			wlim = CMPW'(LINE_MAX);
		end
	end

	assign hlim = (image_height == '0) ? 16'd1 : image_height;
	assign c_last = (CMPW'(col_q) + CMPW'(1)) >= wlim;
	assign k_last = (CMPW'(drn_q) + CMPW'(1)) >= wlim;
	assign rows_done = (row_q >= hlim);
	assign li = (drn_q == '0) ? drn_q : drn_q - AW'(1);
	assign ri = k_last ? drn_q : drn_q + AW'(1);
	assign in_stall = !((state_q == ST_IDLE) && q_room);
	assign accept = in_valid && !in_stall;

	always_comb begin
		unique case (state_q)
			ST_DR1: raddr = li;
			ST_DR2: raddr = ri;
			default: raddr = (in_data.kind == KIND_DRAIN) ? drn_q : col_q;
		endcase
	end

	assign old_wd = (row_q == '0) ? pix_q : prev_rd;

	sem_ram #(.WIDTH(PIX_W), .DEPTH(LINE_MAX), .AW(AW)) u_older (
		.clk(clk), .we(state_q == ST_PIX), .waddr(col_q), .wdata(old_wd),
		.raddr(raddr), .rdata(old_rd)
	);

	sem_ram #(.WIDTH(PIX_W), .DEPTH(LINE_MAX), .AW(AW)) u_prev (
		.clk(clk), .we(state_q == ST_PIX), .waddr(col_q), .wdata(pix_q),
		.raddr(raddr), .rdata(prev_rd)
	);

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			nwin[r*3]     = win_q[r*3 + 1];
			nwin[r*3 + 1] = win_q[r*3 + 2];
		end
		nwin[2] = old_rd;
		nwin[5] = prev_rd;
		nwin[8] = pix_q;
	end

	assign has_a = (row_q != '0) && (col_q != '0);
	assign has_b = (row_q != '0) && c_last;
	assign job_a = build_job(nwin, (col_q >= AW'(2)) ? 2'd0 : 2'd1, 2'd1, 2'd2, 1'b0);
	assign job_b = build_job(nwin, (col_q >= AW'(1)) ? 2'd1 : 2'd2, 2'd2, 2'd2, 1'b1);

	always_comb begin
		job_d.px[0] = tl_q;
		job_d.px[1] = tk_q;
		job_d.px[2] = old_rd;
		job_d.px[3] = ml_q;
		job_d.px[4] = mk_q;
		job_d.px[5] = prev_rd;
		job_d.px[6] = ml_q;
		job_d.px[7] = mk_q;
		job_d.px[8] = prev_rd;
		job_d.eor = k_last;
		job_d.eoi = k_last;
	end

	always_comb begin
		q_push = 1'b0;
		q_data = job_a;
		unique case (state_q)
			ST_PIX: begin
				q_push = has_a || has_b;
				q_data = has_a ? job_a : job_b;
			end
			ST_PIX2: begin
				q_push = 1'b1;
				q_data = jobb_q;
			end
			ST_DR3: begin
				q_push = 1'b1;
				q_data = job_d;
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q <= in_data.pixel_value[PIX_W-1:0];
		end
		if (state_q == ST_PIX) begin
			jobb_q <= job_b;
		end
		if (state_q == ST_DR1) begin
			tk_q <= old_rd;
			mk_q <= prev_rd;
		end
		if (state_q == ST_DR2) begin
			tl_q <= old_rd;
			ml_q <= prev_rd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q <= '0;
			drn_q <= '0;
			row_q <= '0;
			win_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_data.kind == KIND_PIXEL) begin
							if (!rows_done) begin
								state_q <= ST_PIX;
							end
						end else if (rows_done) begin
							state_q <= ST_DR1;
						end
					end
				end
				ST_PIX: begin
					win_q <= nwin;
					if (c_last) begin
						col_q <= '0;
						row_q <= row_q + 16'd1;
					end else begin
						col_q <= col_q + AW'(1);
					end
					state_q <= (has_a && has_b) ? ST_PIX2 : ST_IDLE;
				end
				ST_PIX2: state_q <= ST_IDLE;
				ST_DR1: state_q <= ST_DR2;
				ST_DR2: state_q <= ST_DR3;
				ST_DR3: begin
					if (k_last) begin
						drn_q <= '0;
						row_q <= '0;
						col_q <= '0;
					end else begin
						drn_q <= drn_q + AW'(1);
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[design/sem_back.sv]
// Back part: gradients, sum of squares, bitwise square root, output register.
`timescale 1ns / 1ps
module sem_back import sem_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  job_t      q_data,
	output logic      q_pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);
	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_SQ   = 4'b0010,
		B_ROOT = 4'b0100,
		B_OUT  = 4'b1000
	} bstate_t;

	bstate_t           state_q;
	logic [GRAD_W-1:0] ax_q, ay_q;
	logic [SUM_W-1:0]  s_q;
	logic [MAG_W-1:0]  r_q;
	logic [2:0]        bi_q;
	logic              eor_q, eoi_q;
	logic              out_valid_q;
	out_item_t         out_data_q;

	logic [GRAD_W-1:0] xp, xn, yp, yn;
	logic [MAG_W-1:0]  cand;
	logic [15:0]       cand_sq;
	logic              sat, load;

	assign xp = GRAD_W'(q_data.px[2]) + (GRAD_W'(q_data.px[5]) << 1) + GRAD_W'(q_data.px[8]);
	assign xn = GRAD_W'(q_data.px[0]) + (GRAD_W'(q_data.px[3]) << 1) + GRAD_W'(q_data.px[6]);
	assign yp = GRAD_W'(q_data.px[0]) + (GRAD_W'(q_data.px[1]) << 1) + GRAD_W'(q_data.px[2]);
	assign yn = GRAD_W'(q_data.px[6]) + (GRAD_W'(q_data.px[7]) << 1) + GRAD_W'(q_data.px[8]);

	assign q_pop = (state_q == B_IDLE) && q_valid;
	assign cand = r_q | (MAG_W'(1) << bi_q);
	assign cand_sq = {8'd0, cand} * {8'd0, cand};
	assign sat = (s_q[SUM_W-1:16] != '0);
	assign load = (state_q == B_OUT) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ax_q <= (xp >= xn) ? xp - xn : xn - xp;
			ay_q <= (yp >= yn) ? yp - yn : yn - yp;
			eor_q <= q_data.eor;
			eoi_q <= q_data.eoi;
		end
		if (state_q == B_SQ) begin
			s_q <= SUM_W'(ax_q) * SUM_W'(ax_q) + SUM_W'(ay_q) * SUM_W'(ay_q);
		end
		if (load) begin
			out_data_q.edge_value <= r_q;
			out_data_q.end_of_row <= eor_q;
			out_data_q.end_of_image <= eoi_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			r_q <= '0;
			bi_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						state_q <= B_SQ;
					end
				end
				B_SQ: begin
					r_q <= '0;
					bi_q <= 3'd7;
					state_q <= B_ROOT;
				end
				B_ROOT: begin
					if (sat) begin
						r_q <= '1;
						state_q <= B_OUT;
					end else begin
						if (cand_sq <= s_q[15:0]) begin
							r_q <= cand;
						end
						bi_q <= bi_q - 3'd1;
						if (bi_q == 3'd0) begin
							state_q <= B_OUT;
						end
					end
				end
				B_OUT: begin
					if (load) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule

[design/sobel_edge_magnitude_top.sv]
// Top level of the Sobel 3x3 edge magnitude block.
// Input channel in_valid/in_stall/in_data carries raster pixels (kind pixel) and,
// once all image rows are in, drain transactions that emit the last row.
// Output channel out_valid/out_stall/out_data carries one edge magnitude per
// transaction with end-of-row and end-of-image marks.
// cfg_we/cfg_index/cfg_data write image width and height; write only while idle.
// The front part takes a new transaction only from idle: a pixel passes through
// ST_PIX, and ST_PIX2 when it queues two jobs; a drain passes through ST_DR1,
// ST_DR2 and ST_DR3 for its three line-store reads. A pixel yields 0 to 2 results.
// The back part works on one result at a time: gradients, squares, an 8-step
// bitwise square root and the output register; a saturated sum skips the root.
// Its pace sets the sustained rate.
// A 4-entry job queue separates both parts; the front stalls its input until the
// queue has room for two jobs, and a stalled output backs the queue up.
// Reset clears counters, window and queue; width resets to 1024, height to 1.
// Line stores need no clearing pass.
`timescale 1ns / 1ps
module sobel_edge_magnitude_top import sem_pkg::*; #(
	parameter int LINE_MAX = LINE_MAX_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  cfg_we,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	logic [WIDTH_REG_W-1:0]  image_width_q;
	logic [HEIGHT_REG_W-1:0] image_height_q;
	logic                    q_push, q_pop, q_nonempty, q_room;
	job_t                    q_wdata, q_rdata;
	logic [QCNT_W-1:0]       q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= WIDTH_REG_W'(1024);
			image_height_q <= HEIGHT_REG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_WIDTH: image_width_q <= cfg_data[WIDTH_REG_W-1:0];
				REG_HEIGHT: image_height_q <= cfg_data[HEIGHT_REG_W-1:0];
				default: image_width_q <= image_width_q;
			endcase
		end
	end

	sem_front #(.LINE_MAX(LINE_MAX)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.image_width(image_width_q), .image_height(image_height_q),
		.q_room(q_room), .q_push(q_push), .q_data(q_wdata)
	);

	sem_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .push_data(q_wdata),
		.pop(q_pop), .pop_data(q_rdata),
		.nonempty(q_nonempty), .room2(q_room), .count(q_count)
	);

	sem_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_nonempty), .q_data(q_rdata), .q_pop(q_pop),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push && !q_pop |-> q_count < QCNT_W'(QDEPTH))
		else $error("job queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_count != '0)
		else $error("job queue underflow");

	a_room_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> q_count <= QCNT_W'(QDEPTH - 2))
		else $error("transaction accepted without queue room");
endmodule

[verif/sobel_edge_magnitude_top_tb.sv]
// Testbench for the Sobel edge magnitude block: predicted results checked against the output stream.
`timescale 1ns / 1ps
module sobel_edge_magnitude_top_tb import sem_pkg::*;;

	class edge_scoreboard;
		pix_t prev_row[LINE_MAX_DEF];
		pix_t older_row[LINE_MAX_DEF];
		pix_t win[9];
		int unsigned row_cnt, col_cnt, drain_cnt;
		int unsigned width_reg, height_reg;
		out_item_t pending_edges[$];
		int unsigned mismatches;

		function void clear();
			foreach (win[i]) win[i] = '0;
			foreach (prev_row[i]) begin
				prev_row[i] = '0;
				older_row[i] = '0;
			end
			row_cnt = 0;
			col_cnt = 0;
			drain_cnt = 0;
			width_reg = 1024;
			height_reg = 1;
			mismatches = 0;
			pending_edges.delete();
		endfunction

		function void write_reg(cfg_reg_t idx, int unsigned val);
			if (idx == REG_WIDTH)
				width_reg = val & 11'h7ff;
			else
				height_reg = val & 16'hffff;
		endfunction

		function int unsigned eff_w();
			if (width_reg == 0)
				return 1;
			if (width_reg > LINE_MAX_DEF)
				return LINE_MAX_DEF;
			return width_reg;
		endfunction

		function int unsigned eff_h();
			return (height_reg == 0) ? 1 : height_reg;
		endfunction

		function logic [7:0] magnitude(int t0, int t1, int t2, int m0, int m2,
				int b0, int b1, int b2);
			int gx, gy, s, r, c;
			gx = (t2 + 2 * m2 + b2) - (t0 + 2 * m0 + b0);
			gy = (t0 + 2 * t1 + t2) - (b0 + 2 * b1 + b2);
			s = gx * gx + gy * gy;
			if (s >= 65536)
				return 8'd255;
			r = 0;
			for (int bit_pos = 7; bit_pos >= 0; bit_pos--) begin
				c = r | (1 << bit_pos);
				if (c * c <= s)
					r = c;
			end
			return r[7:0];
		endfunction

		function logic [7:0] window_mag(int li, int ci, int ri);
			return magnitude(win[li], win[ci], win[ri], win[3 + li], win[3 + ri],
				win[6 + li], win[6 + ci], win[6 + ri]);
		endfunction

		function void push_edge(logic [7:0] v, logic eor, logic eoi);
			out_item_t o;
			o.edge_value = v;
			o.end_of_row = eor;
			o.end_of_image = eoi;
			pending_edges.push_back(o);
		endfunction

		function void note_input(in_item_t it);
			int unsigned w, h, c, k, li, ri;
			bit last;
			pix_t p, top, mid;
			w = eff_w();
			h = eff_h();
			if (it.kind == KIND_PIXEL) begin
				if (row_cnt >= h)
					return;
				c = (col_cnt >= LINE_MAX_DEF) ? LINE_MAX_DEF - 1 : col_cnt;
				last = (c + 1 >= w);
				p = it.pixel_value;
				top = older_row[c];
				mid = prev_row[c];
				older_row[c] = (row_cnt == 0) ? p : mid;
				prev_row[c] = p;
				for (int r = 0; r < 3; r++) begin
					win[r * 3] = win[r * 3 + 1];
					win[r * 3 + 1] = win[r * 3 + 2];
				end
				win[2] = top;
				win[5] = mid;
				win[8] = p;
				if (row_cnt >= 1) begin
					if (c >= 1)
						push_edge(window_mag(c >= 2 ? 0 : 1, 1, 2), 1'b0, 1'b0);
					if (last)
						push_edge(window_mag(c >= 1 ? 1 : 2, 2, 2), 1'b1, 1'b0);
				end
				if (last) begin
					col_cnt = 0;
					row_cnt++;
				end else begin
					col_cnt = c + 1;
				end
			end else begin
				if (row_cnt < h)
					return;
				k = (drain_cnt >= LINE_MAX_DEF) ? LINE_MAX_DEF - 1 : drain_cnt;
				li = (k > 0) ? k - 1 : k;
				ri = (k + 1 < w) ? k + 1 : k;
				last = (k + 1 >= w);
				push_edge(magnitude(older_row[li], older_row[k], older_row[ri],
					prev_row[li], prev_row[ri], prev_row[li], prev_row[k], prev_row[ri]),
					last, last);
				if (last) begin
					drain_cnt = 0;
					row_cnt = 0;
					col_cnt = 0;
				end else begin
					drain_cnt = k + 1;
				end
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t exp_item;
			if (pending_edges.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %p", got);
				return;
			end
			exp_item = pending_edges.pop_front();
			if (got !== exp_item) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %p, got %p", exp_item, got);
			end
		endfunction
	endclass

	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	edge_scoreboard sb;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned quiet_cycles;
	int unsigned items_sent;

	sobel_edge_magnitude_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
			if (in_valid && !in_stall)
				sb.note_input(in_data);
			if (out_valid && !out_stall)
				sb.check_result(out_data);
		end
	end

	always @(negedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	task automatic send_item(logic kind, logic [7:0] pix);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_data.kind = kind;
		in_data.pixel_value = pix;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		in_valid = 1'b0;
		items_sent++;
	endtask

	task automatic wait_drained();
		while (sb.pending_edges.size() != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, int unsigned val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = CFG_DATA_W'(val);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic send_image(int unsigned w, int unsigned h, int mode);
		logic [7:0] p;
		for (int r = 0; r < h; r++)
			for (int c = 0; c < w; c++) begin
				case (mode)
					0: p = 8'($urandom);
					1: p = ((r + c) % 2) ? 8'hff : 8'h00;
					default: p = (c < w / 2) ? 8'h00 : 8'hff;
				endcase
				send_item(KIND_PIXEL, p);
			end
		for (int c = 0; c < w; c++)
			send_item(KIND_DRAIN, 8'($urandom));
	endtask

	task automatic run_phase(int unsigned budget);
		int unsigned start, w, h, sel;
		start = items_sent;
		while (items_sent - start < budget) begin
			sel = $urandom_range(9);
			w = (sel == 0) ? $urandom_range(1, 3) : $urandom_range(2, 12);
			h = (sel == 1) ? 1 : $urandom_range(1, 6);
			wait_drained();
			write_reg(REG_WIDTH, w);
			write_reg(REG_HEIGHT, h);
			if (sel == 2) begin
				send_item(KIND_DRAIN, 8'hff);
				send_item(KIND_PIXEL, 8'h5a);
				wait_drained();
				write_reg(REG_HEIGHT, h + 1);
				h = h + 1;
			end
			send_image(w, h, (sel == 3) ? 1 : (sel == 4) ? 2 : 0);
			if (sel == 5)
				send_item(KIND_PIXEL, 8'($urandom));
			if (sel == 6)
				send_item(KIND_DRAIN, 8'($urandom));
			if (sel == 5 || sel == 6) begin
				wait_drained();
				for (int c = 0; c < w; c++)
					send_item(KIND_DRAIN, 8'h00);
			end
		end
	endtask

	initial begin
		sb = new();
		sb.clear();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = REG_WIDTH;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		quiet_cycles = 0;
		items_sent = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_image(1, 1, 1);
		wait_drained();
		write_reg(REG_WIDTH, 3);
		write_reg(REG_HEIGHT, 3);
		send_image(3, 3, 1);
		wait_drained();
		write_reg(REG_WIDTH, 0);
		write_reg(REG_HEIGHT, 0);
		send_item(KIND_DRAIN, 8'h00);
		send_item(KIND_PIXEL, 8'hff);
		send_item(KIND_PIXEL, 8'h00);
		send_item(KIND_DRAIN, 8'h00);
		wait_drained();
		write_reg(REG_WIDTH, 2);
		write_reg(REG_HEIGHT, 2);
		send_image(2, 2, 0);
		wait_drained();
		write_reg(REG_WIDTH, 16);
		write_reg(REG_HEIGHT, 2);
		send_image(16, 2, 0);
		wait_drained();
		write_reg(REG_HEIGHT, 65535);
		send_item(KIND_PIXEL, 8'h81);
		wait_drained();
		write_reg(REG_HEIGHT, 1);
		for (int c = 1; c < 16; c++)
			send_item(KIND_PIXEL, c[7:0]);
		for (int c = 0; c < 16; c++)
			send_item(KIND_DRAIN, 8'h00);
		wait_drained();
		write_reg(REG_WIDTH, 8);
		write_reg(REG_HEIGHT, 2);
		for (int c = 0; c < 5; c++)
			send_item(KIND_PIXEL, 8'($urandom));
		wait_drained();
		write_reg(REG_WIDTH, 3);
		for (int c = 0; c < 4; c++)
			send_item(KIND_PIXEL, 8'($urandom));
		for (int c = 0; c < 3; c++)
			send_item(KIND_DRAIN, 8'h00);

		send_idle_pct = 33;
		recv_idle_pct = 65;
		run_phase(580);
		send_idle_pct = 65;
		recv_idle_pct = 33;
		run_phase(580);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(580);

		while (sb.pending_edges.size() != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending_edges.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
